[sv/fst_pkg.sv]
// Package for the hop-timing follower tracker: shared types and codes.
// No dependencies.
package fst_pkg;

    localparam logic [1:0] CFG_SLOT_MS     = 2'd0;
    localparam logic [1:0] CFG_FINGERPRINT = 2'd1;
    localparam logic [1:0] CFG_CHAN_COUNT  = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HOP  = 2'd1;
    localparam logic [1:0] KIND_SCAN = 2'd2;

    localparam logic [1:0] SYNC_ACQ   = 2'd0;
    localparam logic [1:0] SYNC_TRACK = 2'd1;
    localparam logic [1:0] SYNC_LOST  = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input item
        logic mark_go;   // start marker evaluation
        logic tick_go;   // start tick evaluation
        logic div_start; // start slot division
        logic div_step;  // one restoring step
        logic commit;    // update state and result register
    } fst_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic is_marker;
        logic need_div;
        logic div_done;
    } fst_sts_t;

endpackage

[sv/fst_ctrl.sv]
// Controller state machine for the tracker.
// Depends on fst_pkg.
module fst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  fst_pkg::fst_sts_t sts,
    output fst_pkg::fst_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (sts.is_marker) begin
                    cmd.mark_go = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.tick_go = 1'b1;
                    if (sts.need_div) begin
                        cmd.div_start = 1'b1;
                        state_next = S_DIV;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = S_DONE;
            end
            S_DONE: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end
endmodule

[sv/fst_dp.sv]
// Datapath for the tracker: state registers, marker math, serial divider.
// Depends on fst_pkg.
module fst_dp #(
    parameter int MAX_CHANNELS = 16,
    parameter int TIME_BITS    = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fst_pkg::fst_cmd_t     cmd,
    output fst_pkg::fst_sts_t     sts,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [31:0]           cfg_data,
    input  logic                  in_mode,
    input  logic [47:0]           in_now,
    input  logic                  in_mvalid,
    input  logic [31:0]           in_fp,
    input  logic [31:0]           in_epoch,
    input  logic [31:0]           in_phase,
    input  logic [47:0]           in_mslot,
    output logic [1:0]            o_kind,
    output logic [47:0]           o_rslot,
    output logic [3:0]            o_sidx,
    output logic [1:0]            o_state,
    output logic                  o_acc,
    output logic signed [11:0]    o_err,
    output logic [31:0]           o_mtotal,
    output logic [31:0]           o_lost
);
    localparam int TB = TIME_BITS;
    localparam int AW = TB + 1;        // signed anchor
    localparam int WW = TB + 3;        // wide signed work width
    localparam int SW = 20;            // slot_us width
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DCW = $clog2(TB + 1);
    localparam logic signed [AW-1:0] HI = {1'b0, {TB{1'b1}}};
    localparam logic signed [AW-1:0] LO = {1'b1, {TB{1'b0}}};

    // config
    logic [9:0]  slot_ms_reg;
    logic [31:0] fp_reg;
    logic [4:0]  chan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_ms_reg <= 10'd100;
            fp_reg      <= '0;
            chan_reg    <= 5'd1;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                fst_pkg::CFG_SLOT_MS:     slot_ms_reg <= cfg_data[9:0];
                fst_pkg::CFG_FINGERPRINT: fp_reg      <= cfg_data;
                fst_pkg::CFG_CHAN_COUNT:  chan_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [9:0]    ms_c;
    logic [SW-1:0] slot_us;
    logic [CW-1:0] cnt;
    always_comb begin
        ms_c = slot_ms_reg;
        if (ms_c < 10'd10)   ms_c = 10'd10;
        if (ms_c > 10'd1000) ms_c = 10'd1000;
        if (chan_reg == 5'd0) cnt = CW'(1);
        else if (32'(chan_reg) > 32'(MAX_CHANNELS)) cnt = CW'(MAX_CHANNELS);
        else cnt = CW'(chan_reg);
    end
    always_ff @(posedge aclk) slot_us <= SW'({10'd0, ms_c} * 20'd1000);

    // captured item
    logic          mode_reg, mvalid_reg;
    logic [TB-1:0] now_reg;
    logic [31:0]   fpi_reg, epoch_reg, phase_reg;
    logic [47:0]   mslot_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= in_mode;
            now_reg    <= in_now[TB-1:0];
            mvalid_reg <= in_mvalid;
            fpi_reg    <= in_fp;
            epoch_reg  <= in_epoch;
            phase_reg  <= in_phase;
            mslot_reg  <= in_mslot;
        end
    end

    // tracker state
    logic signed [AW-1:0] anchor_reg;
    logic [31:0]          epoch_h_reg;
    logic [TB-1:0]        lmt_reg;
    logic                 lock_held_reg, tvalid_reg;
    logic [47:0]          tslot_reg;
    logic [PW-1:0]        spos_reg;
    logic [TB:0]          nst_reg;
    logic [1:0]           sc_reg;
    logic signed [12:0]   err_reg;
    logic [31:0]          mcnt_reg, lcnt_reg;

    // marker path: sub computed at load of EVAL through one multiply (48x20)
    logic [67:0]  prod;
    logic         prod_big;
    logic [TB:0]  sub;
    assign prod = {20'd0, mslot_reg} * {48'd0, slot_us};
    always_comb begin
        prod_big = (prod[67:TB] != '0);
        if (prod_big) sub = {1'b1, {TB{1'b0}}};
        else begin
            sub = {1'b0, prod[TB-1:0]} + (TB+1)'(phase_reg);
            if (sub > {1'b1, {TB{1'b0}}}) sub = {1'b1, {TB{1'b0}}};
        end
    end
    // observed = now - sub, in [-2^TB, 2^TB-1]
    logic signed [AW-1:0] observed;
    assign observed = AW'($signed({1'b0, now_reg}) - $signed(sub));

    logic                 m_ok;
    logic signed [WW-1:0] diff;
    logic signed [12:0]   err_c;
    logic signed [12:0]   q;
    logic signed [WW-1:0] nudged;
    logic                 reanchor;
    assign m_ok = mvalid_reg && (fpi_reg == fp_reg) && (phase_reg < 32'(slot_us));
    assign reanchor = (anchor_reg == '0) || (epoch_h_reg != epoch_reg);
    always_comb begin
        diff = WW'(observed) - WW'(anchor_reg);
        if (diff > WW'(2000))       err_c = 13'sd2000;
        else if (diff < -WW'(2000)) err_c = -13'sd2000;
        else                        err_c = diff[12:0];
        q = err_c / 13'sd4;
        nudged = WW'(anchor_reg) + WW'(q);
    end

    // tick path
    logic signed [WW-1:0] age, since;
    logic                 tracking;
    always_comb begin
        age = WW'($signed({1'b0, now_reg})) - WW'($signed({1'b0, lmt_reg}));
        since = WW'($signed({1'b0, now_reg})) - WW'(anchor_reg);
        tracking = (anchor_reg > 0) && (lmt_reg != '0) &&
                   (age < $signed(WW'({2'b0, slot_us} * 22'd3)));
    end

    // restoring divider: since / slot_us
    logic [TB-1:0]  dq_reg;
    logic [SW:0]    dr_reg;
    logic [DCW-1:0] dc_reg;
    logic [SW:0]    dtry;
    assign dtry = {dr_reg[SW-1:0], dq_reg[TB-1]} - {1'b0, slot_us};
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dq_reg <= since[TB-1:0];
            dr_reg <= '0;
            dc_reg <= '0;
        end else if (cmd.div_step) begin
            if (!dtry[SW]) begin
                dr_reg <= dtry;
                dq_reg <= {dq_reg[TB-2:0], 1'b1};
            end else begin
                dr_reg <= {dr_reg[SW-1:0], dq_reg[TB-1]};
                dq_reg <= {dq_reg[TB-2:0], 1'b0};
            end
            dc_reg <= dc_reg + 1'b1;
        end
    end

    assign sts.is_marker = mode_reg;
    assign sts.need_div  = tracking && (since > 0);
    assign sts.div_done  = (dc_reg == DCW'(TB - 1));

    // evaluation latched at EVAL
    logic        t_track_reg, t_div_reg, m_ok_reg;
    always_ff @(posedge aclk) begin
        if (cmd.mark_go || cmd.tick_go) begin
            t_track_reg <= tracking;
            t_div_reg   <= tracking && (since > 0);
            m_ok_reg    <= m_ok;
        end
    end

    // scan position modulo channel count: short compare-subtract chain
    logic [47:0]      tslot;
    logic [PW-1:0]    sidx;
    logic [CW+PW-1:0] pmod;
    assign tslot = t_div_reg ? 48'(dq_reg) : 48'd0;
    always_comb begin
        pmod = (CW+PW)'(spos_reg);
        for (int k = PW - 1; k >= 0; k--) begin
            if (pmod >= ((CW+PW)'(cnt) << k)) pmod = pmod - ((CW+PW)'(cnt) << k);
        end
        sidx = PW'(pmod);
    end

    // marker updates latched at EVAL
    logic signed [AW-1:0] m_anchor_reg;
    logic signed [12:0]   m_err_reg;
    always_ff @(posedge aclk) begin
        if (cmd.mark_go) begin
            if (reanchor) begin
                m_anchor_reg <= observed;
                m_err_reg    <= '0;
            end else begin
                if (nudged > WW'(HI))      m_anchor_reg <= HI;
                else if (nudged < WW'(LO)) m_anchor_reg <= LO;
                else                       m_anchor_reg <= nudged[AW-1:0];
                m_err_reg <= err_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_reg    <= '0;
            epoch_h_reg   <= '0;
            lmt_reg       <= '0;
            lock_held_reg <= 1'b0;
            tvalid_reg    <= 1'b0;
            tslot_reg     <= '0;
            spos_reg      <= '0;
            nst_reg       <= '0;
            sc_reg        <= fst_pkg::SYNC_ACQ;
            err_reg       <= '0;
            mcnt_reg      <= '0;
            lcnt_reg      <= '0;
            o_kind        <= fst_pkg::KIND_NONE;
            o_rslot       <= '0;
            o_sidx        <= '0;
            o_acc         <= 1'b0;
        end else if (cmd.commit) begin
            o_kind  <= fst_pkg::KIND_NONE;
            o_rslot <= '0;
            o_sidx  <= '0;
            o_acc   <= 1'b0;
            if (mode_reg) begin
                if (m_ok_reg) begin
                    anchor_reg  <= m_anchor_reg;
                    epoch_h_reg <= epoch_reg;
                    lmt_reg     <= now_reg;
                    err_reg     <= m_err_reg;
                    mcnt_reg    <= mcnt_reg + 1'b1;
                    o_acc       <= 1'b1;
                end
            end else if (t_track_reg) begin
                lock_held_reg <= 1'b1;
                sc_reg        <= fst_pkg::SYNC_TRACK;
                if (!tvalid_reg || tslot > tslot_reg) begin
                    o_kind     <= fst_pkg::KIND_HOP;
                    o_rslot    <= tslot;
                    tslot_reg  <= tslot;
                    tvalid_reg <= 1'b1;
                end
            end else begin
                // lock loss starts a scan at once, so the state lands on acquiring
                if (lock_held_reg) begin
                    lcnt_reg      <= lcnt_reg + 1'b1;
                    lock_held_reg <= 1'b0;
                    tvalid_reg    <= 1'b0;
                    tslot_reg     <= '0;
                end
                if (lock_held_reg || ({1'b0, now_reg} >= nst_reg)) begin
                    o_kind   <= fst_pkg::KIND_SCAN;
                    o_sidx   <= 4'(sidx);
                    spos_reg <= ((CW+1)'(sidx) + 1'b1 >= (CW+1)'(cnt)) ?
                                '0 : PW'(sidx + 1'b1);
                    nst_reg  <= {1'b0, now_reg} + (TB+1)'({slot_us, 1'b0});
                    sc_reg   <= fst_pkg::SYNC_ACQ;
                end
            end
        end
    end

    assign o_state  = sc_reg;
    assign o_err    = err_reg[11:0];
    assign o_mtotal = mcnt_reg;
    assign o_lost   = lcnt_reg;
endmodule

[sv/fhss_follower_sync_tracker_top.sv]
// Top level of the hop-timing follower tracker.
// Depends on fst_pkg, fst_ctrl, fst_dp.
//
// Usage:
//   s_axis: one input item per transaction. tdata (lowest bit first):
//     now_us[48], marker_valid[1], marker_fingerprint[32], marker_epoch[32],
//     marker_phase_us[32], marker_slot[48]; tuser = mode (0 tick, 1 marker).
//   m_axis: one result per item. tdata: retune_kind[2], retune_slot[48],
//     scan_index[4], sync_state[2], marker_accepted[1], phase_err[12],
//     markers_total[32], reacquisitions[32].
//   cfg: index 0 slot_ms, 1 expected_fingerprint, 2 channel_count;
//     write only while idle.
// Markers and non-tracking ticks pass from accept through the evaluate,
// commit and output states; tracking ticks with a positive offset also run
// the bit-serial division of elapsed time by slot length before commit.
// One item is in flight at a time; the next is accepted at the earliest in
// the cycle after the result transaction completes.
// Reset (aresetn low, synchronous) clears all tracking state and restores
// register defaults. If m_axis_tready is low the result holds and
// s_axis_tready stays low.
module fhss_follower_sync_tracker_top #(
    parameter int MAX_CHANNELS = 16,
    parameter int TIME_BITS    = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,  // now_us, marker_valid, fp, epoch, phase, slot
    input  logic         s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // kind, slot, scan, state, acc, err, total, reacq
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    fst_pkg::fst_cmd_t cmd;
    fst_pkg::fst_sts_t sts;

    logic [1:0]         kind, st;
    logic [47:0]        rslot;
    logic [3:0]         sidx;
    logic               acc;
    logic signed [11:0] err;
    logic [31:0]        mtot, lost;

    assign cfg_ready = 1'b1;

    fst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fst_dp #(.MAX_CHANNELS(MAX_CHANNELS), .TIME_BITS(TIME_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .in_mode   (s_axis_tuser),
        .in_now    (s_axis_tdata[47:0]),
        .in_mvalid (s_axis_tdata[48]),
        .in_fp     (s_axis_tdata[80:49]),
        .in_epoch  (s_axis_tdata[112:81]),
        .in_phase  (s_axis_tdata[144:113]),
        .in_mslot  (s_axis_tdata[192:145]),
        .o_kind    (kind),
        .o_rslot   (rslot),
        .o_sidx    (sidx),
        .o_state   (st),
        .o_acc     (acc),
        .o_err     (err),
        .o_mtotal  (mtot),
        .o_lost    (lost)
    );

    assign m_axis_tdata = {3'b0, lost, mtot, err, acc, st, sidx, rslot, kind};

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
    a_acc_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[56]) |-> (m_axis_tdata[1:0] == fst_pkg::KIND_NONE))
        else $error("accepted marker with retune");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("duplicate result");
`endif
endmodule

[dv/fhss_follower_sync_tracker_top_tb.sv]
// Self-checking testbench for fhss_follower_sync_tracker_top: directed and random
// tick/marker streams, scored against an in-bench model of the tracker.
// Depends on fst_pkg and the RTL under sv/.
module fhss_follower_sync_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TLIM   = 64'd1 << 48;
    localparam longint ANC_HI = TLIM - 1;
    localparam longint ANC_LO = -TLIM;
    localparam int     SETTLE = 60;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] data;
        bit          mode;
        logic [47:0] now;
        bit          mvalid;
        logic [31:0] fp;
        logic [31:0] epoch;
        logic [31:0] phase;
        logic [47:0] mslot;
    } item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [47:0] rslot;
        logic [3:0]  scan;
        logic [1:0]  sync;
        logic        acc;
        logic [11:0] err;
        logic [31:0] total;
        logic [31:0] reacq;
    } timing_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;  // now_us, marker_valid, fp, epoch, phase, slot
    logic         s_axis_tuser = 0;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [135:0] m_axis_tdata;       // kind, slot, scan, state, acc, err, total, reacq
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    fhss_follower_sync_tracker_top dut (.*);

    initial forever #2 aclk = ~aclk;

    // tracker model state
    logic [9:0]  cfg_slot_ms = 10'd100;
    logic [31:0] cfg_fp = '0;
    logic [4:0]  cfg_chans = 5'd1;
    longint      anchor = 0, last_mark = 0, scan_due = 0, err_reg = 0;
    logic [31:0] held_epoch = '0, mark_cnt = '0, lost_cnt = '0;
    bit          lock_held = 0, tuned_ok = 0;
    logic [47:0] tuned = '0;
    longint      scan_pos = 0;
    logic [1:0]  sync_code = fst_pkg::SYNC_ACQ;

    item_t   pending[$];
    timing_t expected[$];
    item_t   cur;
    int      accepted = 0, errors = 0, quiet = 0;
    bit      no_idle = 0;

    function automatic longint slot_len_us();
        longint ms = longint'(cfg_slot_ms);
        if (ms < 10) ms = 10;
        if (ms > 1000) ms = 1000;
        return ms * 1000;
    endfunction

    function automatic timing_t track_step(item_t it);
        timing_t r;
        longint su = slot_len_us();
        longint now = longint'({16'b0, it.now});
        longint sub, obs, e, q, since, slot, cnt, idx;
        r = '{default: '0};
        if (it.mode) begin
            if (it.mvalid && it.fp == cfg_fp && longint'({32'b0, it.phase}) < su) begin
                e = 0;
                if (longint'({16'b0, it.mslot}) > TLIM / su) sub = TLIM;
                else begin
                    sub = longint'({16'b0, it.mslot}) * su + longint'({32'b0, it.phase});
                    if (sub > TLIM) sub = TLIM;
                end
                obs = now - sub;
                if (anchor == 0 || held_epoch != it.epoch) anchor = obs;
                else begin
                    e = obs - anchor;
                    if (e > 2000) e = 2000;
                    if (e < -2000) e = -2000;
                    q = e / 4;
                    if (q > 0 && anchor > ANC_HI - q) anchor = ANC_HI;
                    else if (q < 0 && anchor < ANC_LO - q) anchor = ANC_LO;
                    else anchor += q;
                end
                held_epoch = it.epoch;
                last_mark = now;
                err_reg = e;
                mark_cnt++;
                r.acc = 1'b1;
            end
        end else if (anchor > 0 && last_mark > 0 && (now - last_mark) < 3 * su) begin
            since = now - anchor;
            slot = since > 0 ? since / su : 0;
            lock_held = 1'b1;
            if (!tuned_ok || slot[47:0] > tuned) begin
                r.kind = fst_pkg::KIND_HOP;
                r.rslot = slot[47:0];
                tuned = slot[47:0];
                tuned_ok = 1'b1;
            end
            sync_code = fst_pkg::SYNC_TRACK;
        end else begin
            if (lock_held) begin
                sync_code = fst_pkg::SYNC_LOST;
                lost_cnt++;
                lock_held = 1'b0;
                tuned_ok = 1'b0;
                tuned = '0;
                scan_due = 0;
            end
            if (now >= scan_due) begin
                cnt = longint'(cfg_chans);
                if (cnt < 1) cnt = 1;
                if (cnt > 16) cnt = 16;
                idx = scan_pos % cnt;
                r.kind = fst_pkg::KIND_SCAN;
                r.scan = idx[3:0];
                scan_pos = (idx + 1) % cnt;
                scan_due = now + 2 * su;
                sync_code = fst_pkg::SYNC_ACQ;
            end
        end
        r.sync = sync_code;
        r.err = err_reg[11:0];
        r.total = mark_cnt;
        r.reacq = lost_cnt;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        bit busy_in, busy_cfg;
        if (!aresetn) begin
            s_axis_tvalid <= 0;
            cfg_valid <= 0;
            quiet <= 0;
        end else begin
            busy_in = s_axis_tvalid;
            busy_cfg = cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected.push_back(track_step(cur));
                accepted++;
                busy_in = 0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fst_pkg::CFG_SLOT_MS:     cfg_slot_ms = cfg_data[9:0];
                    fst_pkg::CFG_FINGERPRINT: cfg_fp = cfg_data;
                    fst_pkg::CFG_CHAN_COUNT:  cfg_chans = cfg_data[4:0];
                    default: ;
                endcase
                busy_cfg = 0;
            end
            no_idle = accepted >= 700 && accepted < 1000;
            if (!busy_in && !busy_cfg && pending.size() > 0) begin
                if (pending[0].is_cfg) begin
                    if (expected.size() == 0 && quiet >= SETTLE) begin
                        cfg_index <= pending[0].idx;
                        cfg_data <= pending[0].data;
                        busy_cfg = 1;
                        void'(pending.pop_front());
                    end
                end else if (no_idle || $urandom_range(99) >= 34) begin
                    cur = pending.pop_front();
                    s_axis_tdata <= {7'b0, cur.mslot, cur.phase, cur.epoch, cur.fp,
                                     cur.mvalid, cur.now};
                    s_axis_tuser <= cur.mode;
                    busy_in = 1;
                end
            end
            quiet <= (busy_in || busy_cfg || expected.size() != 0) ? 0
                     : (quiet < 255 ? quiet + 1 : quiet);
            s_axis_tvalid <= busy_in;
            cfg_valid <= busy_cfg;
        end
    end

    task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        timing_t e;
        if (!aresetn) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result transaction");
                end else begin
                    e = expected.pop_front();
                    check_field("retune_kind", 48'(e.kind), 48'(m_axis_tdata[1:0]));
                    check_field("retune_slot", e.rslot, m_axis_tdata[49:2]);
                    check_field("scan_index", 48'(e.scan), 48'(m_axis_tdata[53:50]));
                    check_field("sync_state", 48'(e.sync), 48'(m_axis_tdata[55:54]));
                    check_field("marker_accepted", 48'(e.acc), 48'(m_axis_tdata[56]));
                    check_field("phase_err", 48'(e.err), 48'(m_axis_tdata[68:57]));
                    check_field("markers_total", 48'(e.total), 48'(m_axis_tdata[100:69]));
                    check_field("reacquisitions", 48'(e.reacq), 48'(m_axis_tdata[132:101]));
                end
            end
            m_axis_tready <= no_idle || $urandom_range(99) >= 34;
        end
    end

    // stimulus
    initial begin
        item_t  it;
        longint su, now, base, d, ph, fp;
        logic [31:0] ep;
        int r;
        int unsigned slot_set[6]  = '{100, 10, 1000, 0, 1023, 0};
        int unsigned chan_set[6]  = '{1, 16, 4, 0, 31, 0};

        it = '{default: '0};
        // directed, default registers: slot 100 ms, fingerprint 0, one channel
        su = 100000;
        it.mode = 0; it.now = 0;                          pending.push_back(it);
        it.now = 48'd5_000_000;                           pending.push_back(it);
        it.mode = 1; it.mvalid = 0;                       pending.push_back(it);
        it.mvalid = 1; it.fp = 32'hFFFF_FFFF;             pending.push_back(it);
        it.fp = 0; it.phase = 32'd100000;                 pending.push_back(it);
        it.phase = 32'hFFFF_FFFF;                         pending.push_back(it);
        it.phase = 32'd99999; it.mslot = 48'd40; it.epoch = 32'd7;
        it.now = 48'd5_100_000;                           pending.push_back(it);
        it.mode = 0; it.now = 48'd5_150_000;              pending.push_back(it);
        it.now = 48'd5_250_000;                           pending.push_back(it);
        it.mode = 1; it.now = 48'd5_301_000; it.mslot = 48'd42; it.phase = 32'd5000;
        pending.push_back(it);
        it.mode = 1; it.now = 48'd5_302_000; it.phase = 32'd0; pending.push_back(it);
        it.mode = 0; it.now = 48'd5_100_000;              pending.push_back(it);
        it.now = 48'd6_000_000;                           pending.push_back(it);
        it.now = 48'd6_250_000;                           pending.push_back(it);
        it.mode = 1; it.now = 48'hFFFF_FFFF_FFFF; it.mslot = 48'hFFFF_FFFF_FFFF;
        it.epoch = 32'hFFFF_FFFF; it.phase = 32'd1;       pending.push_back(it);
        it.mslot = 48'd0;                                 pending.push_back(it);
        it.mode = 0;                                      pending.push_back(it);
        it.now = 48'd1; it.mode = 1; it.mslot = 48'd2_814_749_767; it.epoch = 32'd3;
        pending.push_back(it);
        it.mode = 0; it.now = 48'd2;                      pending.push_back(it);

        now = 64'd1_000_000_000;
        for (int p = 0; p < 6; p++) begin
            it = '{default: '0};
            it.is_cfg = 1;
            it.idx = fst_pkg::CFG_SLOT_MS;
            it.data = p == 5 ? $urandom_range(10, 200) : {$urandom} & ~32'h3FF | slot_set[p];
            pending.push_back(it);
            it.idx = fst_pkg::CFG_FINGERPRINT;
            it.data = p == 1 ? 32'hFFFF_FFFF : (p == 2 ? 32'h0 : $urandom);
            fp = longint'(it.data);
            pending.push_back(it);
            it.idx = fst_pkg::CFG_CHAN_COUNT;
            it.data = p == 5 ? $urandom_range(1, 16) : {$urandom} & ~32'h1F | chan_set[p];
            pending.push_back(it);
            su = slot_set[p];
            if (p == 5) su = pending[pending.size() - 3].data[9:0];
            if (su < 10) su = 10;
            if (su > 1000) su = 1000;
            su *= 1000;
            if (p == 4) now = TLIM - 64'd400 * su;
            base = now - $urandom_range(2, 30) * su - $urandom_range(0, su - 1);
            ep = $urandom;
            for (int n = 0; n < 300; n++) begin
                it = '{default: '0};
                it.fp = fp[31:0];
                it.epoch = ep;
                it.mvalid = 1;
                r = $urandom_range(99);
                if (r < 55) begin
                    now += (r < 3) ? 4 * su : $urandom_range(0, su / 2);
                    it.mode = 0;
                end else if (r < 88) begin
                    if (r >= 85) begin
                        ep = $urandom;
                        base -= $urandom_range(0, 3 * su);
                        it.epoch = ep;
                    end
                    now += $urandom_range(0, 3000);
                    it.mode = 1;
                    d = now - base;
                    ph = d % su + $urandom_range(0, 8000) - 4000;
                    if (ph < 0) ph = 0;
                    if (ph >= su) ph = su - 1;
                    it.mslot = 48'(d / su);
                    it.phase = ph[31:0];
                end else begin
                    it.mode = $urandom_range(1);
                    it.mslot = {$urandom, $urandom};
                    it.phase = $urandom_range(1) ? $urandom : su + $urandom_range(0, 3);
                    it.epoch = $urandom;
                    case ($urandom_range(3))
                        0: it.mvalid = 0;
                        1: it.fp = $urandom;
                        2: now -= $urandom_range(0, 2 * su);
                        default: it.mvalid = $urandom_range(1);
                    endcase
                end
                it.now = now[47:0];
                pending.push_back(it);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1;
        do @(posedge aclk);
        while (pending.size() != 0 || s_axis_tvalid || expected.size() != 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
